// ===== rtl/q2e_pkg.sv =====
// q2e_pkg: shared widths, latencies and the CORDIC angle table for the
// quaternion to Euler angle converter. No dependencies.
package q2e_pkg;

  // internal widths
  localparam int EFF_MAX   = 24;  // components are cut down to this width
  localparam int CORDIC_W  = 34;  // CORDIC x/y datapath
  localparam int Z_W       = 26;  // angle accumulator, degrees with 16 fraction bits
  localparam int PS_W      = 33;  // pitch sine/cosine pair handed to the CORDIC
  localparam int MIN_NORM_W = 16;
  localparam int ROLL_W    = 16;
  localparam int PITCH_W   = 15;
  localparam int YAW_W     = 16;
  localparam int ANG_TABLE_LEN = 24;

  localparam logic [MIN_NORM_W-1:0] MIN_NORM_RESET = 16'd268;

  // pipeline latencies of the fixed units
  localparam int NORM_LAT    = 3;
  localparam int ISQRT_STEPS = 32;
  localparam int PITCH_LAT   = 4 + ISQRT_STEPS;

  localparam logic signed [Z_W-1:0] ANG_P90 = 26'sd5898240;
  localparam logic signed [Z_W-1:0] ANG_N90 = -26'sd5898240;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic signed [Z_W-1:0] ang_entry(input logic [4:0] idx);
    logic signed [Z_W-1:0] r;
    unique case (idx)
      5'd0:  r = 26'sd2949120;
      5'd1:  r = 26'sd1740967;
      5'd2:  r = 26'sd919879;
      5'd3:  r = 26'sd466945;
      5'd4:  r = 26'sd234378;
      5'd5:  r = 26'sd117304;
      5'd6:  r = 26'sd58666;
      5'd7:  r = 26'sd29335;
      5'd8:  r = 26'sd14668;
      5'd9:  r = 26'sd7334;
      5'd10: r = 26'sd3667;
      5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;
      5'd13: r = 26'sd458;
      5'd14: r = 26'sd229;
      5'd15: r = 26'sd115;
      5'd16: r = 26'sd57;
      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;
      5'd19: r = 26'sd7;
      5'd20: r = 26'sd4;
      5'd21: r = 26'sd2;
      5'd22: r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/q2e_quat_if.sv =====
// q2e_quat_if: valid/ready channel carrying one quaternion request.
// No dependencies.
interface q2e_quat_if #(parameter int QUAT_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [QUAT_WIDTH-1:0] quat_w;
  logic signed [QUAT_WIDTH-1:0] quat_x;
  logic signed [QUAT_WIDTH-1:0] quat_y;
  logic signed [QUAT_WIDTH-1:0] quat_z;

  modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== rtl/q2e_euler_if.sv =====
// q2e_euler_if: valid/ready channel carrying one set of Euler angles.
// Depends on q2e_pkg for the field widths.
interface q2e_euler_if import q2e_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [ROLL_W-1:0]  roll_angle;
  logic signed [PITCH_W-1:0] pitch_angle;
  logic signed [YAW_W-1:0]   yaw_angle;
  logic                      status;

  modport source(output valid, roll_angle, pitch_angle, yaw_angle, status, input ready);
  modport sink(input valid, roll_angle, pitch_angle, yaw_angle, status, output ready);
endinterface

// ===== rtl/q2e_isqrt.sv =====
// q2e_isqrt: pipelined 64-bit integer square root, one result bit per stage.
// Depends on q2e_pkg.
module q2e_isqrt import q2e_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  logic [63:0] rem [0:ISQRT_STEPS];
  logic [63:0] res [0:ISQRT_STEPS];

  assign rem[0] = radicand;
  assign res[0] = '0;

  for (genvar g = 0; g < ISQRT_STEPS; g++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
    logic [63:0] trial;
    logic [63:0] rem_next;
    logic [63:0] res_next;

    // try subtracting the next root bit
    always_comb begin
      trial = res[g] + BIT;
      if (rem[g] >= trial) begin
        rem_next = rem[g] - trial;
        res_next = (res[g] >> 1) + BIT;
      end else begin
        rem_next = rem[g];
        res_next = res[g] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= rem_next;
        res[g+1] <= res_next;
      end
    end
  end

  assign root = res[ISQRT_STEPS][31:0];

endmodule

// ===== rtl/q2e_pitch_prep.sv =====
// q2e_pitch_prep: scales the pitch sine against the norm, clamps it and
// builds the matching cosine through q2e_isqrt. Depends on q2e_pkg and q2e_isqrt.
module q2e_pitch_prep import q2e_pkg::*; #(
  parameter int SW = 35
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [SW-1:0] norm_sq,
  input  logic signed [SW-1:0] sine,
  output logic signed [PS_W-1:0] sine_out,
  output logic signed [PS_W-1:0] cosine_out
);

  localparam int LEN_W = $clog2(SW + 1);
  localparam int XW    = SW + 32;

  // stage 1: bit length of the norm, shift amounts
  logic [LEN_W-1:0] len;
  logic signed [SW-1:0] p1_n, p1_s;
  logic [LEN_W-1:0] p1_rsh, p1_lsh;

  always_comb begin
    len = '0;
    for (int i = 0; i < SW; i++) begin
      if (norm_sq[i]) len = LEN_W'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_n   <= norm_sq;
      p1_s   <= sine;
      p1_rsh <= (len > LEN_W'(31)) ? len - LEN_W'(31) : '0;
      p1_lsh <= (len < LEN_W'(30)) ? LEN_W'(30) - len : '0;
    end
  end

  // stage 2: bring the norm into [2^29, 2^31), sine along with it
  logic [XW-1:0]        pn_w;
  logic signed [XW-1:0] s_w;
  logic signed [PS_W-1:0] p2_pn, p2_s;

  always_comb begin
    pn_w = (XW'($unsigned(p1_n)) >> p1_rsh) << p1_lsh;
    s_w  = (XW'(p1_s) >>> p1_rsh) <<< p1_lsh;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_pn <= {1'b0, pn_w[PS_W-2:0]};
      p2_s  <= s_w[PS_W-1:0];
    end
  end

  // stage 3: clamp the sine, form norm-sine and norm+sine
  logic signed [PS_W-1:0] s_cl;
  logic signed [PS_W:0]   dif, sm;
  logic signed [PS_W-1:0] p3_s;
  logic [31:0] p3_dif, p3_sum;

  always_comb begin
    s_cl = p2_s;
    if (p2_s > p2_pn) s_cl = p2_pn;
    if (p2_s < -p2_pn) s_cl = -p2_pn;
    dif = (PS_W+1)'(p2_pn) - (PS_W+1)'(s_cl);
    sm  = (PS_W+1)'(p2_pn) + (PS_W+1)'(s_cl);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_s   <= s_cl;
      p3_dif <= dif[31:0];
      p3_sum <= sm[31:0];
    end
  end

  // stage 4: cosine squared, scaled
  logic signed [PS_W-1:0] p4_s;
  logic [63:0] p4_prod;

  always_ff @(posedge clk) begin
    if (en) begin
      p4_s    <= p3_s;
      p4_prod <= p3_dif * p3_sum;
    end
  end

  // square root; sine rides alongside
  logic [31:0] root;
  logic signed [PS_W-1:0] s_dly [0:ISQRT_STEPS-1];

  q2e_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (p4_prod),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      s_dly[0] <= p4_s;
      for (int i = 1; i < ISQRT_STEPS; i++) s_dly[i] <= s_dly[i-1];
    end
  end

  assign sine_out   = s_dly[ISQRT_STEPS-1];
  assign cosine_out = {1'b0, root};

endmodule

// ===== rtl/q2e_norm.sv =====
// q2e_norm: scales an (x, y) pair so the larger magnitude lands in
// [2^28, 2^30) ahead of the CORDIC. Depends on q2e_pkg.
module q2e_norm import q2e_pkg::*; #(
  parameter int IN_W = 35
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [IN_W-1:0]     x_in,
  input  logic signed [IN_W-1:0]     y_in,
  output logic signed [CORDIC_W-1:0] x_out,
  output logic signed [CORDIC_W-1:0] y_out,
  output logic                       zero
);

  localparam int LEN_W = $clog2(IN_W + 2);
  localparam int WW    = IN_W + CORDIC_W;
  localparam logic signed [WW-1:0] LIM_P = WW'(1 << 30);
  localparam logic signed [WW-1:0] LIM_N = -LIM_P;

  // stage 1: larger magnitude
  logic [IN_W-1:0] mx, my;
  logic signed [IN_W-1:0] s1_x, s1_y;
  logic [IN_W-1:0] s1_m;

  always_comb begin
    mx = x_in[IN_W-1] ? IN_W'(-x_in) : IN_W'(x_in);
    my = y_in[IN_W-1] ? IN_W'(-y_in) : IN_W'(y_in);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x <= x_in;
      s1_y <= y_in;
      s1_m <= (mx > my) ? mx : my;
    end
  end

  // stage 2: bit length and shift amounts
  logic [LEN_W-1:0] len;
  logic signed [IN_W-1:0] s2_x, s2_y;
  logic [LEN_W-1:0] s2_rsh, s2_lsh;
  logic s2_zero;

  always_comb begin
    len = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (s1_m[i]) len = LEN_W'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x    <= s1_x;
      s2_y    <= s1_y;
      s2_zero <= (len == '0);
      s2_rsh  <= (len > LEN_W'(30)) ? len - LEN_W'(30) : '0;
      s2_lsh  <= (len < LEN_W'(29) && len != '0) ? LEN_W'(29) - len : '0;
    end
  end

  // stage 3: apply the shift; a floor shift of a negative value may need one more
  logic signed [WW-1:0] xw, yw, xa, ya, xb, yb, xl, yl;
  logic ok_a;
  logic signed [CORDIC_W-1:0] x_sel, y_sel;

  always_comb begin
    xw = WW'(s2_x);
    yw = WW'(s2_y);
    xa = xw >>> s2_rsh;
    ya = yw >>> s2_rsh;
    xb = xw >>> (s2_rsh + LEN_W'(1));
    yb = yw >>> (s2_rsh + LEN_W'(1));
    xl = xw <<< s2_lsh;
    yl = yw <<< s2_lsh;
    ok_a = (xa < LIM_P) && (xa > LIM_N) && (ya < LIM_P) && (ya > LIM_N);
    if (s2_rsh == '0) begin
      x_sel = xl[CORDIC_W-1:0];
      y_sel = yl[CORDIC_W-1:0];
    end else if (ok_a) begin
      x_sel = xa[CORDIC_W-1:0];
      y_sel = ya[CORDIC_W-1:0];
    end else begin
      x_sel = xb[CORDIC_W-1:0];
      y_sel = yb[CORDIC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= x_sel;
      y_out <= y_sel;
      zero  <= s2_zero;
    end
  end

endmodule

// ===== rtl/q2e_cordic.sv =====
// q2e_cordic: pipelined vectoring CORDIC giving atan2(y, x) in degrees with
// 16 fraction bits. Depends on q2e_pkg and q2e_norm.
module q2e_cordic import q2e_pkg::*; #(
  parameter int IN_W  = 35,
  parameter int STEPS = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [IN_W-1:0] x_in,
  input  logic signed [IN_W-1:0] y_in,
  output logic signed [Z_W-1:0]  angle
);

  logic signed [CORDIC_W-1:0] nx, ny;
  logic nzero;

  q2e_norm #(.IN_W(IN_W)) u_norm (
    .clk   (clk),
    .en    (en),
    .x_in  (x_in),
    .y_in  (y_in),
    .x_out (nx),
    .y_out (ny),
    .zero  (nzero)
  );

  logic signed [CORDIC_W-1:0] cx [0:STEPS];
  logic signed [CORDIC_W-1:0] cy [0:STEPS];
  logic signed [Z_W-1:0]      cz [0:STEPS];
  logic                       cf [0:STEPS];

  // turn a vector in the left half plane by +/-90 degrees
  always_ff @(posedge clk) begin
    if (en) begin
      cf[0] <= nzero;
      if (nx <= 0) begin
        if (ny >= 0) begin
          cx[0] <= ny;
          cy[0] <= -nx;
          cz[0] <= ANG_P90;
        end else begin
          cx[0] <= -ny;
          cy[0] <= nx;
          cz[0] <= ANG_N90;
        end
      end else begin
        cx[0] <= nx;
        cy[0] <= ny;
        cz[0] <= '0;
      end
    end
  end

  // one micro-rotation per stage
  for (genvar g = 0; g < STEPS; g++) begin : g_iter
    logic signed [CORDIC_W-1:0] xs, ys;
    assign xs = cx[g] >>> g;
    assign ys = cy[g] >>> g;

    always_ff @(posedge clk) begin
      if (en) begin
        cf[g+1] <= cf[g];
        if (cy[g] > 0) begin
          cx[g+1] <= cx[g] + ys;
          cy[g+1] <= cy[g] - xs;
          cz[g+1] <= cz[g] + ang_entry(5'(g));
        end else begin
          cx[g+1] <= cx[g] - ys;
          cy[g+1] <= cy[g] + xs;
          cz[g+1] <= cz[g] - ang_entry(5'(g));
        end
      end
    end
  end

  // zero vector reads as zero angle
  assign angle = cf[STEPS] ? '0 : cz[STEPS];

endmodule

// ===== rtl/quaternion_to_euler.sv =====
// quaternion_to_euler: top level of the quaternion to ZYX Euler angle
// converter. Depends on q2e_pkg, q2e_quat_if, q2e_euler_if, q2e_pitch_prep, q2e_cordic.

// Takes a new quaternion request every clock unless the output is held, and
// returns roll, pitch and yaw in degrees with 7 fraction bits, in order, one
// result per request. The path runs through stages A, B and C (input cut,
// products, sums), the pitch cosine (scaling, clamp, a 32x32 multiply and a
// one-bit-per-stage square root), three CORDIC pipelines of the same shape
// and one output register. The whole pipeline advances together; it holds
// only while a finished result sits in the output register and is not taken.
// A quaternion whose squared norm is at or below min_norm_sq (written through
// cfg_we/cfg_wdata, reset 268) comes back with status 1 and zero angles.
module quaternion_to_euler import q2e_pkg::*; #(
  parameter int QUAT_WIDTH   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [MIN_NORM_W-1:0]  cfg_wdata,
  q2e_quat_if.sink               quat_in,
  q2e_euler_if.source            euler_out
);

  localparam int EFF    = (QUAT_WIDTH > EFF_MAX) ? EFF_MAX : QUAT_WIDTH;
  localparam int PW     = 2 * EFF;
  localparam int SW     = 2 * EFF + 3;
  localparam int FR2    = 2 * (EFF - 2);
  localparam int LSH_N  = (FR2 < 28) ? 28 - FR2 : 0;
  localparam int LSH_M  = (FR2 >= 28) ? FR2 - 28 : 0;
  localparam int CMP_W  = SW + 32;
  localparam int CORDIC_LAT = NORM_LAT + 1 + CORDIC_STEPS;
  localparam int BAD_D  = PITCH_LAT + CORDIC_LAT;
  localparam int LAT    = 3 + BAD_D + 1;

  logic en;
  logic [LAT-1:0] vld;
  logic [MIN_NORM_W-1:0] min_norm_sq;

  // advance everything unless the output is held
  assign en = !vld[LAT-1] || euler_out.ready;
  assign quat_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_norm_sq <= MIN_NORM_RESET;
    end else if (cfg_we) begin
      min_norm_sq <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], quat_in.valid};
    end
  end

  // stage A: keep the top EFF bits (floor shift of wide inputs)
  logic signed [EFF-1:0] a_w, a_x, a_y, a_z;

  always_ff @(posedge clk) begin
    if (en) begin
      a_w <= quat_in.quat_w[QUAT_WIDTH-1 -: EFF];
      a_x <= quat_in.quat_x[QUAT_WIDTH-1 -: EFF];
      a_y <= quat_in.quat_y[QUAT_WIDTH-1 -: EFF];
      a_z <= quat_in.quat_z[QUAT_WIDTH-1 -: EFF];
    end
  end

  // stage B: component products
  logic signed [PW-1:0] b_ww, b_xx, b_yy, b_zz, b_wx, b_yz, b_wy, b_zx, b_wz, b_xy;

  always_ff @(posedge clk) begin
    if (en) begin
      b_ww <= a_w * a_w;
      b_xx <= a_x * a_x;
      b_yy <= a_y * a_y;
      b_zz <= a_z * a_z;
      b_wx <= a_w * a_x;
      b_yz <= a_y * a_z;
      b_wy <= a_w * a_y;
      b_zx <= a_z * a_x;
      b_wz <= a_w * a_z;
      b_xy <= a_x * a_y;
    end
  end

  // stage C: norm, atan2 operands, threshold check
  logic signed [SW-1:0] n_next, roll_y_next, roll_x_next, yaw_y_next, yaw_x_next, s_next;
  logic [CMP_W-1:0] cmp_n, cmp_m;
  logic signed [SW-1:0] c_n, c_s, c_roll_y, c_roll_x, c_yaw_y, c_yaw_x;
  logic c_bad;

  always_comb begin
    n_next      = SW'(b_ww) + SW'(b_xx) + SW'(b_yy) + SW'(b_zz);
    roll_y_next = (SW'(b_wx) + SW'(b_yz)) <<< 1;
    roll_x_next = n_next - ((SW'(b_xx) + SW'(b_yy)) <<< 1);
    yaw_y_next  = (SW'(b_wz) + SW'(b_xy)) <<< 1;
    yaw_x_next  = n_next - ((SW'(b_yy) + SW'(b_zz)) <<< 1);
    s_next      = (SW'(b_wy) - SW'(b_zx)) <<< 1;
    cmp_n       = CMP_W'($unsigned(n_next)) << LSH_N;
    cmp_m       = CMP_W'(min_norm_sq) << LSH_M;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_n      <= n_next;
      c_s      <= s_next;
      c_roll_y <= roll_y_next;
      c_roll_x <= roll_x_next;
      c_yaw_y  <= yaw_y_next;
      c_yaw_x  <= yaw_x_next;
      c_bad    <= (cmp_n <= cmp_m);
    end
  end

  // pitch sine and cosine
  logic signed [PS_W-1:0] p_sine, p_cos;

  q2e_pitch_prep #(.SW(SW)) u_pitch_prep (
    .clk        (clk),
    .en         (en),
    .norm_sq    (c_n),
    .sine       (c_s),
    .sine_out   (p_sine),
    .cosine_out (p_cos)
  );

  // hold roll and yaw operands alongside the pitch work
  logic signed [SW-1:0] d_roll_y [0:PITCH_LAT-1];
  logic signed [SW-1:0] d_roll_x [0:PITCH_LAT-1];
  logic signed [SW-1:0] d_yaw_y  [0:PITCH_LAT-1];
  logic signed [SW-1:0] d_yaw_x  [0:PITCH_LAT-1];
  logic bad_pipe [0:BAD_D-1];

  always_ff @(posedge clk) begin
    if (en) begin
      d_roll_y[0] <= c_roll_y;
      d_roll_x[0] <= c_roll_x;
      d_yaw_y[0]  <= c_yaw_y;
      d_yaw_x[0]  <= c_yaw_x;
      for (int i = 1; i < PITCH_LAT; i++) begin
        d_roll_y[i] <= d_roll_y[i-1];
        d_roll_x[i] <= d_roll_x[i-1];
        d_yaw_y[i]  <= d_yaw_y[i-1];
        d_yaw_x[i]  <= d_yaw_x[i-1];
      end
      bad_pipe[0] <= c_bad;
      for (int i = 1; i < BAD_D; i++) bad_pipe[i] <= bad_pipe[i-1];
    end
  end

  // three angle pipelines
  logic signed [Z_W-1:0] roll_z, pitch_z, yaw_z;

  q2e_cordic #(.IN_W(SW), .STEPS(CORDIC_STEPS)) u_roll (
    .clk   (clk),
    .en    (en),
    .x_in  (d_roll_x[PITCH_LAT-1]),
    .y_in  (d_roll_y[PITCH_LAT-1]),
    .angle (roll_z)
  );

  q2e_cordic #(.IN_W(PS_W), .STEPS(CORDIC_STEPS)) u_pitch (
    .clk   (clk),
    .en    (en),
    .x_in  (p_cos),
    .y_in  (p_sine),
    .angle (pitch_z)
  );

  q2e_cordic #(.IN_W(SW), .STEPS(CORDIC_STEPS)) u_yaw (
    .clk   (clk),
    .en    (en),
    .x_in  (d_yaw_x[PITCH_LAT-1]),
    .y_in  (d_yaw_y[PITCH_LAT-1]),
    .angle (yaw_z)
  );

  // round to 7 fraction bits, zero the angles of a rejected quaternion
  logic signed [Z_W:0] roll_r, pitch_r, yaw_r;
  logic signed [ROLL_W-1:0]  o_roll;
  logic signed [PITCH_W-1:0] o_pitch;
  logic signed [YAW_W-1:0]   o_yaw;
  logic o_status;

  always_comb begin
    roll_r  = ((Z_W+1)'(roll_z) + (Z_W+1)'(256)) >>> 9;
    pitch_r = ((Z_W+1)'(pitch_z) + (Z_W+1)'(256)) >>> 9;
    yaw_r   = ((Z_W+1)'(yaw_z) + (Z_W+1)'(256)) >>> 9;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_status <= bad_pipe[BAD_D-1];
      o_roll   <= bad_pipe[BAD_D-1] ? '0 : roll_r[ROLL_W-1:0];
      o_pitch  <= bad_pipe[BAD_D-1] ? '0 : pitch_r[PITCH_W-1:0];
      o_yaw    <= bad_pipe[BAD_D-1] ? '0 : yaw_r[YAW_W-1:0];
    end
  end

  assign euler_out.valid       = vld[LAT-1];
  assign euler_out.roll_angle  = o_roll;
  assign euler_out.pitch_angle = o_pitch;
  assign euler_out.yaw_angle   = o_yaw;
  assign euler_out.status      = o_status;

  // a rejected quaternion reports zero angles
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (euler_out.valid && euler_out.status) |->
      (o_roll == '0 && o_pitch == '0 && o_yaw == '0))
    else $error("rejected quaternion with nonzero angles");

  // an accepted request occupies the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (quat_in.valid && quat_in.ready) |=> vld[0])
    else $error("accepted request lost at entry");

  // held output keeps the pipeline frozen
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (euler_out.valid && !euler_out.ready) |=> $stable(vld))
    else $error("pipeline moved while output held");

  // pitch stays inside +/-90 degrees
  a_pitch_rng: assert property (@(posedge clk) disable iff (rst)
    euler_out.valid |-> (o_pitch <= 15'sd11520 && o_pitch >= -15'sd11520))
    else $error("pitch out of range");

endmodule

// ===== tb/tb_quaternion_to_euler.sv =====
// tb_quaternion_to_euler: self-checking testbench for the quaternion to Euler
// angle converter. Depends on q2e_pkg, q2e_quat_if, q2e_euler_if and the RTL.
// Directed table first, then random quaternions over several thresholds.
`timescale 1ns / 1ps

module tb_quaternion_to_euler;
  import q2e_pkg::*;

  localparam int QW        = 16;
  localparam int LATENCY   = 44 + 16;
  localparam int WATCHDOG  = 3000;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [ROLL_W-1:0]  roll;
    logic signed [PITCH_W-1:0] pitch;
    logic signed [YAW_W-1:0]   yaw;
    logic                      status;
  } euler_t;

  typedef struct {
    quat_t  q;
    bit     typed;
    euler_t e;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [MIN_NORM_W-1:0] cfg_wdata = '0;

  q2e_quat_if #(.QUAT_WIDTH(QW)) quat_if();
  q2e_euler_if euler_if();

  quaternion_to_euler #(.QUAT_WIDTH(QW), .CORDIC_STEPS(16)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .quat_in(quat_if), .euler_out(euler_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and bookkeeping
  logic [MIN_NORM_W-1:0] threshold = MIN_NORM_RESET;
  euler_t angles_due[$];
  euler_t typed_due[$];
  bit     typed_flag[$];
  int     errors = 0;
  bit     send_idle = 1'b1;
  bit     hold_request = 1'b0;
  bit     stim_done = 1'b0;
  int     quiet_cycles = 0;

  // atan2(y, x), degrees with 16 fraction bits
  function automatic longint atan2_deg(longint y, longint x);
    longint ang, t, xs, ys;
    longint unsigned ax, ay, m;
    ang = 0;
    forever begin
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      m = (ax > ay) ? ax : ay;
      if (m == 0) return 0;
      if (m >= (64'd1 << 30)) begin
        x = x >>> 1;
        y = y >>> 1;
      end else if (m < (64'd1 << 28)) begin
        x = x * 2;
        y = y * 2;
      end else break;
    end
    if (x <= 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; ang = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; ang = -90 * 65536;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; ang += ang_entry(i[4:0]);
      end else begin
        x = x - ys; y = y + xs; ang -= ang_entry(i[4:0]);
      end
    end
    return ang;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_deg7(longint a);
    return (a + 256) >>> 9;
  endfunction

  function automatic euler_t euler_of(quat_t q, logic [MIN_NORM_W-1:0] thr);
    longint w, x, y, z, n, s, pn;
    longint unsigned c;
    euler_t e;
    w = q.w; x = q.x; y = q.y; z = q.z;
    n = w * w + x * x + y * y + z * z;
    e = '0;
    // norm too small: zero angles, status set
    if (n <= longint'(thr)) begin
      e.status = 1'b1;
      return e;
    end
    e.roll = ROLL_W'(round_deg7(atan2_deg(2 * (w * x + y * z),
                                          n - 2 * (x * x + y * y))));
    s = 2 * (w * y - z * x);
    pn = n;
    while (pn >= (64'sd1 <<< 31)) begin
      pn >>= 1;
      s = s >>> 1;
    end
    while (pn > 0 && pn < (64'sd1 <<< 29)) begin
      pn *= 2;
      s *= 2;
    end
    if (s > pn) s = pn;
    if (s < -pn) s = -pn;
    c = int_sqrt(longint'(unsigned'(pn - s)) * longint'(unsigned'(pn + s)));
    e.pitch = PITCH_W'(round_deg7(atan2_deg(s, longint'(c))));
    e.yaw = YAW_W'(round_deg7(atan2_deg(2 * (w * z + x * y),
                                        n - 2 * (y * y + z * z))));
    return e;
  endfunction

  // record expectation at each accepted request
  always @(posedge clk) begin
    if (!rst && quat_if.valid && quat_if.ready)
      angles_due.push_back(euler_of({quat_if.quat_w, quat_if.quat_x,
                                     quat_if.quat_y, quat_if.quat_z}, threshold));
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    euler_t got, want, typed;
    bit has_typed;
    if (!rst && euler_if.valid && euler_if.ready) begin
      got = {euler_if.roll_angle, euler_if.pitch_angle, euler_if.yaw_angle,
             euler_if.status};
      if (angles_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = angles_due.pop_front();
        has_typed = typed_flag.size() > 0 ? typed_flag.pop_front() : 1'b0;
        typed = (typed_due.size() > 0) ? typed_due.pop_front() : want;
        if (has_typed && typed != want) begin
          errors++;
          $display("%0t: table row disagrees: typed %h predicted %h", $time, typed, want);
        end
        if (got.roll !== want.roll) begin
          errors++;
          $display("%0t: roll expected %0d actual %0d", $time, want.roll, got.roll);
        end
        if (got.pitch !== want.pitch) begin
          errors++;
          $display("%0t: pitch expected %0d actual %0d", $time, want.pitch, got.pitch);
        end
        if (got.yaw !== want.yaw) begin
          errors++;
          $display("%0t: yaw expected %0d actual %0d", $time, want.yaw, got.yaw);
        end
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((quat_if.valid && quat_if.ready) || (euler_if.valid && euler_if.ready) || rst)
      quiet_cycles <= 0;
    else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    int burst;
    euler_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        euler_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
        euler_if.ready <= 1'b1;
      end else if (send_idle && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 14);
        euler_if.ready <= 1'b0;
        repeat (burst - 1) @(posedge clk);
      end else begin
        euler_if.ready <= !rst;
      end
    end
  end

  // offer one request, at times with a random gap in front, and wait for acceptance
  task automatic offer(quat_t q);
    int gap;
    if (send_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      quat_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    quat_if.valid  <= 1'b1;
    quat_if.quat_w <= q.w;
    quat_if.quat_x <= q.x;
    quat_if.quat_y <= q.y;
    quat_if.quat_z <= q.z;
    do @(posedge clk); while (!(quat_if.valid && quat_if.ready));
  endtask

  // drain the pipeline, then write the threshold
  task automatic set_threshold(logic [MIN_NORM_W-1:0] v);
    quat_if.valid <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    threshold <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [QW-1:0] pick_comp(int kind);
    case (kind)
      0: return QW'($urandom);
      1: return QW'($signed($urandom_range(0, 40)) - 20);
      default: return QW'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic quat_t random_quat();
    quat_t q;
    int kind, sel;
    sel = $urandom_range(0, 9);
    kind = (sel < 3) ? 0 : (sel < 5) ? 1 : 2;
    q.w = pick_comp(kind);
    q.x = pick_comp(kind);
    q.y = pick_comp(kind);
    q.z = pick_comp(kind);
    // y = +-w and z = +-x, signs drawn apart, plus small offsets; near gimbal lock when the signs differ
    if (sel == 9) begin
      q.y = ($urandom_range(0, 1) ? q.w : -q.w) + QW'($signed($urandom_range(0, 4)) - 2);
      q.z = ($urandom_range(0, 1) ? q.x : -q.x) + QW'($signed($urandom_range(0, 4)) - 2);
    end
    return q;
  endfunction

  dir_row_t dir_rows[$];

  function automatic dir_row_t row(int w, int x, int y, int z, bit typed,
                                   int r, int p, int yw, bit st);
    dir_row_t d;
    d.q = {QW'(w), QW'(x), QW'(y), QW'(z)};
    d.typed = typed;
    d.e = {ROLL_W'(r), PITCH_W'(p), YAW_W'(yw), st};
    return d;
  endfunction

  initial begin
    logic [MIN_NORM_W-1:0] phase_thr [5];
    quat_if.valid  = 1'b0;
    quat_if.quat_w = '0;
    quat_if.quat_x = '0;
    quat_if.quat_y = '0;
    quat_if.quat_z = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: zero and tiny quaternions, identity, extremes, gimbal lock
    dir_rows.push_back(row(0, 0, 0, 0, 1, 0, 0, 0, 1));
    dir_rows.push_back(row(16, 0, 0, 0, 1, 0, 0, 0, 1));
    dir_rows.push_back(row(17, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(16384, 0, 0, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(row(-16384, 0, 0, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(row(0, 16384, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(0, 0, 16384, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(0, 0, 0, 16384, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(-32768, -32768, -32768, -32768, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(32767, 32767, 32767, 32767, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(32767, -32768, 32767, -32768, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(-32768, 32767, 0, -1, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(11585, 0, 11585, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(11585, 0, -11585, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(11585, 3, 11585, -3, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(1, 1, 1, -1, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(0, 16384, 0, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(0, 16384, 0, -1, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(-1, -1, -1, -1, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(8192, -8192, 8192, -8192, 0, 0, 0, 0, 0));
    foreach (dir_rows[i]) begin
      typed_flag.push_back(dir_rows[i].typed);
      typed_due.push_back(dir_rows[i].e);
      offer(dir_rows[i].q);
    end

    // thresholds 0, the maximum, a random value, 1 and the reset value, random requests in each
    phase_thr[0] = 16'd0;
    phase_thr[1] = 16'hFFFF;
    phase_thr[2] = MIN_NORM_W'($urandom);
    phase_thr[3] = 16'd1;
    phase_thr[4] = MIN_NORM_RESET;
    for (int ph = 0; ph < 5; ph++) begin
      set_threshold(phase_thr[ph]);
      if (ph == 0) offer('0);
      for (int k = 0; k < 140; k++) begin
        if (ph == 2 && k == 20) hold_request = 1'b1;
        if (ph == 4 && k == 40) send_idle = 1'b0;
        offer(random_quat());
      end
    end
    quat_if.valid <= 1'b0;
    stim_done = 1'b1;

    while (angles_due.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0 && typed_due.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
